@@ rtl/tqmc_pkg.sv @@
// Package for the tetrahedron quality minimum checker.
// Holds sequencer states, register indexes, reset values and the determinant term table.
// No dependencies.
`default_nettype none

package tqmc_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int QFRAC_BITS_DEF = 48;

  // Configuration register indexes
  localparam int REG_IDX_BITS = 2;
  localparam logic [REG_IDX_BITS-1:0] REG_QUALITY_FLOOR = 2'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_INITIAL_WORST = 2'd1;

  localparam logic [63:0] QUALITY_FLOOR_RST = 64'd6;
  localparam logic [63:0] INITIAL_WORST_RST = 64'd27084942262351;

  // Micro-program steps: 18 squared edges, 6 two-step determinant terms,
  // then S^2, S^3 and vol^2
  localparam int STEP_BITS = 6;
  localparam logic [STEP_BITS-1:0] STEP_SQ_LAST    = 6'd17;
  localparam logic [STEP_BITS-1:0] STEP_TERM_FIRST = 6'd18;
  localparam logic [STEP_BITS-1:0] STEP_TERM_LAST  = 6'd29;
  localparam logic [STEP_BITS-1:0] STEP_S2         = 6'd30;
  localparam logic [STEP_BITS-1:0] STEP_S3         = 6'd31;
  localparam logic [STEP_BITS-1:0] STEP_V2         = 6'd32;

  // det(u,v,w) terms: u[a] * v[b] * w[c], negated where TERM_NEG is set
  localparam logic [1:0] TERM_U_SEL [6] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2};
  localparam logic [1:0] TERM_V_SEL [6] = '{2'd1, 2'd2, 2'd2, 2'd0, 2'd0, 2'd1};
  localparam logic [1:0] TERM_W_SEL [6] = '{2'd2, 2'd1, 2'd0, 2'd2, 2'd1, 2'd0};
  localparam logic       TERM_NEG   [6] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_COMMIT,
    ST_DIV,
    ST_SQRT,
    ST_FIN
  } tqmc_state_e;

endpackage

`default_nettype wire

@@ rtl/tet_quality_min_check_core.sv @@
// Tetrahedron quality and running minimum checker, top level.
// Uses tqmc_pkg for states, register indexes and the determinant term table.
`default_nettype none

// Corners stream in one request each; corners 0..2 are stored and return
// nothing. Corner 3 starts the quality computation on a single shared
// wide adder: 33 shift-add multiplies (18 squared edges, 6 determinant terms in
// two passes, S^2, S^3, vol^2), then a restoring divide that yields
// 2*QUALITY_FRAC_BITS quotient bits and a square root that yields QUALITY_FRAC_BITS
// root bits. A non-positive volume finishes after the determinant.
// The input is not ready while a corner 3 is at work; one finished result may
// wait in the output register while the next corners are taken.
module tet_quality_min_check_core
  import tqmc_pkg::*;
#(
  parameter int COORD_BITS        = COORD_BITS_DEF,
  parameter int QUALITY_FRAC_BITS = QFRAC_BITS_DEF,
  localparam int InW  = ((3 * COORD_BITS + 2 + 7) / 8) * 8,
  localparam int OutW = ((2 * QUALITY_FRAC_BITS + 1 + 7) / 8) * 8
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Corner requests
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  // {pad, corner, coord_z, coord_y, coord_x} from the lowest bit up: coord_x first
  input  wire logic [InW-1:0]               s_axis_tdata,
  // skip_tet
  input  wire logic                         s_axis_tuser,
  // last_tet
  input  wire logic                         s_axis_tlast,
  // Results
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // from the lowest bit: tet_quality, worst_quality, mesh_ok, zero pad
  output logic [OutW-1:0]                   m_axis_tdata,
  // was_skipped
  output logic                              m_axis_tuser,
  // mesh_done
  output logic                              m_axis_tlast,
  // Configuration writes
  input  wire logic                         cfg_we_i,
  input  wire logic [REG_IDX_BITS-1:0]      cfg_idx_i,
  input  wire logic [QUALITY_FRAC_BITS-1:0] cfg_wdata_i
);

  localparam int CB   = COORD_BITS;
  localparam int F    = QUALITY_FRAC_BITS;
  localparam int DB   = CB + 1;
  localparam int VB   = 3 * DB + 3;
  localparam int SB   = 2 * DB + 5;
  localparam int W    = 3 * SB + 1;
  localparam int MB   = VB;
  localparam int QW   = 2 * F;
  localparam int CNTW = $clog2(QW + 1);

  function automatic logic [DB-1:0] mag(input logic signed [DB-1:0] v);
    logic [DB-1:0] r;
    r = v[DB-1] ? (~v + 1'b1) : v;
    return r;
  endfunction

  tqmc_state_e state_q, state_d;

  logic [STEP_BITS-1:0] step_q, step_d;
  logic [CNTW-1:0]      cnt_q, cnt_d;

  logic signed [CB-1:0] hold_q [3][3];
  logic signed [DB-1:0] u_q [3], v_q [3], w_q [3];
  logic signed [DB-1:0] u_d [3], v_d [3], w_d [3];
  logic signed [DB-1:0] edge_val [18];

  logic skip_q, skip_d, last_q, last_d, neg_q, neg_d;

  logic [W-1:0]   ma_q, ma_d, mp_q, mp_d, tmp_q, tmp_d;
  logic [MB-1:0]  mb_q, mb_d;
  logic [W-1:0]   s_q, s_d, s3_q, s3_d, vol_q, vol_d, rem_q, rem_d;
  logic [QW-1:0]  quo_q, quo_d;
  logic [F+1:0]   srem_q, srem_d;
  logic [F-1:0]   root_q, root_d;

  logic [F-1:0] floor_q, init_q, worst_q, worst_d;

  logic         out_valid_q, out_valid_d;
  logic [F-1:0] out_qual_q, out_qual_d, out_worst_q, out_worst_d;
  logic         out_ok_q, out_ok_d, out_skip_q, out_skip_d, out_last_q, out_last_d;

  // Shared adder / subtractor
  logic [W-1:0] alu_a, alu_b;
  logic         alu_sub;
  logic [W:0]   alu_r;

  assign alu_r = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (W + 1)'(alu_sub);

  logic signed [CB-1:0] in_x, in_y, in_z;
  logic [1:0]           in_corner;
  logic                 in_acc;

  assign in_x      = s_axis_tdata[CB-1:0];
  assign in_y      = s_axis_tdata[2*CB-1:CB];
  assign in_z      = s_axis_tdata[3*CB-1:2*CB];
  assign in_corner = s_axis_tdata[3*CB+1:3*CB];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc    = s_axis_tvalid && s_axis_tready;

  // Edge vectors: a-b, a-c, a-d squared equal u, v, w squared
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      edge_val[k]      = u_q[k];
      edge_val[3 + k]  = v_q[k];
      edge_val[6 + k]  = w_q[k];
      edge_val[9 + k]  = v_q[k] - u_q[k];
      edge_val[12 + k] = w_q[k] - u_q[k];
      edge_val[15 + k] = w_q[k] - v_q[k];
    end
  end

  logic [STEP_BITS-1:0]  tidx;
  logic [2:0]            tsel;
  logic signed [DB-1:0]  tx, ty, tz;
  logic [F+3:0]          sq_shift;
  logic [F-1:0]          new_worst;

  assign tidx = step_q - STEP_TERM_FIRST;
  assign tsel = tidx[3:1];
  assign tx   = u_q[TERM_U_SEL[tsel]];
  assign ty   = v_q[TERM_V_SEL[tsel]];
  assign tz   = w_q[TERM_W_SEL[tsel]];
  assign sq_shift  = {srem_q, quo_q[QW-1 -: 2]};
  assign new_worst = (!skip_q && (root_q < worst_q)) ? root_q : worst_q;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cnt_d   = cnt_q;
    u_d     = u_q;
    v_d     = v_q;
    w_d     = w_q;
    skip_d  = skip_q;
    last_d  = last_q;
    neg_d   = neg_q;
    ma_d    = ma_q;
    mb_d    = mb_q;
    mp_d    = mp_q;
    tmp_d   = tmp_q;
    s_d     = s_q;
    s3_d    = s3_q;
    vol_d   = vol_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    srem_d  = srem_q;
    root_d  = root_q;
    worst_d = worst_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_qual_d  = out_qual_q;
    out_worst_d = out_worst_q;
    out_ok_d    = out_ok_q;
    out_skip_d  = out_skip_q;
    out_last_d  = out_last_q;
    alu_a   = mp_q;
    alu_b   = ma_q;
    alu_sub = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_corner == 2'd3)) begin
          for (int k = 0; k < 3; k++) begin
            u_d[k] = DB'(hold_q[1][k]) - DB'(hold_q[0][k]);
            v_d[k] = DB'(hold_q[2][k]) - DB'(hold_q[0][k]);
          end
          w_d[0]  = DB'(in_x) - DB'(hold_q[0][0]);
          w_d[1]  = DB'(in_y) - DB'(hold_q[0][1]);
          w_d[2]  = DB'(in_z) - DB'(hold_q[0][2]);
          skip_d  = s_axis_tuser;
          last_d  = s_axis_tlast;
          step_d  = '0;
          s_d     = '0;
          vol_d   = '0;
          state_d = ST_LOAD;
        end
      end

      ST_LOAD: begin
        mp_d    = '0;
        state_d = ST_MUL;
        if (step_q <= STEP_SQ_LAST) begin
          ma_d = W'(mag(edge_val[step_q[4:0]]));
          mb_d = MB'(mag(edge_val[step_q[4:0]]));
        end else if (step_q inside {[STEP_TERM_FIRST:STEP_TERM_LAST]}) begin
          if (!tidx[0]) begin
            ma_d  = W'(mag(tx));
            mb_d  = MB'(mag(ty));
            neg_d = TERM_NEG[tsel] ^ tx[DB-1] ^ ty[DB-1] ^ tz[DB-1];
          end else begin
            ma_d = tmp_q;
            mb_d = MB'(mag(tz));
          end
        end else if (step_q == STEP_S2) begin
          // Non-positive volume: quality is zero
          if (vol_q[W-1] || (vol_q == '0)) begin
            root_d  = '0;
            state_d = ST_FIN;
          end else begin
            ma_d = s_q;
            mb_d = MB'(s_q);
          end
        end else if (step_q == STEP_S3) begin
          ma_d = tmp_q;
          mb_d = MB'(s_q);
        end else begin
          ma_d = vol_q;
          mb_d = MB'(vol_q);
        end
      end

      ST_MUL: begin
        if (mb_q != '0) begin
          if (mb_q[0]) begin
            mp_d = alu_r[W-1:0];
          end
          ma_d = {ma_q[W-2:0], 1'b0};
          mb_d = mb_q >> 1;
        end else begin
          state_d = ST_COMMIT;
        end
      end

      ST_COMMIT: begin
        step_d  = step_q + 1'b1;
        state_d = ST_LOAD;
        alu_b   = mp_q;
        if (step_q <= STEP_SQ_LAST) begin
          alu_a = s_q;
          s_d   = alu_r[W-1:0];
        end else if (step_q inside {[STEP_TERM_FIRST:STEP_TERM_LAST]}) begin
          if (!tidx[0]) begin
            tmp_d = mp_q;
          end else begin
            alu_a   = vol_q;
            alu_sub = neg_q;
            vol_d   = alu_r[W-1:0];
          end
        end else if (step_q == STEP_S2) begin
          tmp_d = mp_q;
        end else if (step_q == STEP_S3) begin
          s3_d = mp_q;
        end else begin
          // vol^2 < S^3, so the quotient fits in 2F bits
          rem_d   = mp_q;
          quo_d   = '0;
          cnt_d   = '0;
          state_d = ST_DIV;
        end
      end

      ST_DIV: begin
        alu_a   = {rem_q[W-2:0], 1'b0};
        alu_b   = s3_q;
        alu_sub = 1'b1;
        rem_d   = alu_r[W] ? alu_r[W-1:0] : alu_a;
        quo_d   = {quo_q[QW-2:0], alu_r[W]};
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == CNTW'(QW - 1)) begin
          cnt_d   = '0;
          srem_d  = '0;
          root_d  = '0;
          state_d = ST_SQRT;
        end
      end

      ST_SQRT: begin
        alu_a   = W'(sq_shift);
        alu_b   = W'({root_q, 2'b01});
        alu_sub = 1'b1;
        srem_d  = alu_r[W] ? alu_r[F+1:0] : sq_shift[F+1:0];
        root_d  = {root_q[F-2:0], alu_r[W]};
        quo_d   = {quo_q[QW-3:0], 2'b00};
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == CNTW'(F - 1)) begin
          state_d = ST_FIN;
        end
      end

      ST_FIN: begin
        // Hold until the output register is free
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_qual_d  = root_q;
          out_worst_d = new_worst;
          out_ok_d    = (new_worst >= floor_q);
          out_skip_d  = skip_q;
          out_last_d  = last_q;
          worst_d     = last_q ? init_q : new_worst;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      floor_q     <= QUALITY_FLOOR_RST[F-1:0];
      init_q      <= INITIAL_WORST_RST[F-1:0];
      worst_q     <= INITIAL_WORST_RST[F-1:0];
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      worst_q     <= worst_d;
      if (cfg_we_i && (cfg_idx_i == REG_QUALITY_FLOOR)) begin
        floor_q <= cfg_wdata_i;
      end
      if (cfg_we_i && (cfg_idx_i == REG_INITIAL_WORST)) begin
        init_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (in_corner != 2'd3)) begin
      hold_q[in_corner][0] <= in_x;
      hold_q[in_corner][1] <= in_y;
      hold_q[in_corner][2] <= in_z;
    end
    step_q      <= step_d;
    cnt_q       <= cnt_d;
    u_q         <= u_d;
    v_q         <= v_d;
    w_q         <= w_d;
    skip_q      <= skip_d;
    last_q      <= last_d;
    neg_q       <= neg_d;
    ma_q        <= ma_d;
    mb_q        <= mb_d;
    mp_q        <= mp_d;
    tmp_q       <= tmp_d;
    s_q         <= s_d;
    s3_q        <= s3_d;
    vol_q       <= vol_d;
    rem_q       <= rem_d;
    quo_q       <= quo_d;
    srem_q      <= srem_d;
    root_q      <= root_d;
    out_qual_q  <= out_qual_d;
    out_worst_q <= out_worst_d;
    out_ok_q    <= out_ok_d;
    out_skip_q  <= out_skip_d;
    out_last_q  <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutW'({out_ok_q, out_worst_q, out_qual_q});
  assign m_axis_tuser  = out_skip_q;
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// Testbench for tet_quality_min_check_core: streams tetrahedron corners, predicts each
// quality and running minimum in a scoreboard class and checks every result request.
// Depends on tqmc_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;
  import tqmc_pkg::*;

  localparam int CW = 24;
  localparam int QW = 48;
  localparam int IN_W = 80;
  localparam int OUT_W = 104;
  localparam logic [REG_IDX_BITS-1:0] REG_SPARE = 2'd2;
  localparam logic [QW-1:0] QMAX = {QW{1'b1}};
  localparam int SETTLE_CYCLES = 1400;

  typedef logic signed [255:0] s256_t;
  typedef logic [511:0] u512_t;

  typedef struct {
    logic signed [CW-1:0] x, y, z;
    logic [1:0] corner;
    logic skip, last;
  } corner_t;

  typedef struct {
    logic [QW-1:0] quality, worst;
    logic ok, skipped, done;
  } tet_result_t;

  class quality_board;
    longint held[3][3];
    logic [QW-1:0] floor_q, init_worst, min_worst;
    tet_result_t pending[$];
    int mismatches;

    function new();
      floor_q = QUALITY_FLOOR_RST[QW-1:0];
      init_worst = INITIAL_WORST_RST[QW-1:0];
      min_worst = init_worst;
      mismatches = 0;
    endfunction

    function void write_reg(logic [REG_IDX_BITS-1:0] idx, logic [QW-1:0] val);
      if (idx == REG_QUALITY_FLOOR) floor_q = val;
      else if (idx == REG_INITIAL_WORST) init_worst = val;
    endfunction

    // floor(2^48 * vol / S^1.5), zero for a non-positive volume
    function logic [QW-1:0] tet_quality(longint p[4][3]);
      longint u[3], v[3], w[3];
      s256_t vol;
      u512_t s, s3, rhs, lhs, t;
      logic [QW-1:0] q;
      q = '0;
      for (int k = 0; k < 3; k++) begin
        u[k] = p[1][k] - p[0][k];
        v[k] = p[2][k] - p[0][k];
        w[k] = p[3][k] - p[0][k];
      end
      vol = s256_t'(u[0]) * s256_t'(v[1]) * s256_t'(w[2])
          - s256_t'(u[0]) * s256_t'(v[2]) * s256_t'(w[1])
          + s256_t'(u[1]) * s256_t'(v[2]) * s256_t'(w[0])
          - s256_t'(u[1]) * s256_t'(v[0]) * s256_t'(w[2])
          + s256_t'(u[2]) * s256_t'(v[0]) * s256_t'(w[1])
          - s256_t'(u[2]) * s256_t'(v[1]) * s256_t'(w[0]);
      if (vol <= 0) return '0;
      s = '0;
      for (int i = 0; i < 4; i++)
        for (int j = i + 1; j < 4; j++)
          for (int k = 0; k < 3; k++)
            s = s + u512_t'((p[j][k] - p[i][k]) * (p[j][k] - p[i][k]));
      s3 = s * s * s;
      rhs = (u512_t'(vol) * u512_t'(vol)) << (2 * QW);
      for (int b = QW - 1; b >= 0; b--) begin
        t = u512_t'(q | (QW'(1) << b));
        lhs = t * t * s3;
        if (lhs <= rhs) q = q | (QW'(1) << b);
      end
      return q;
    endfunction

    function void note_corner(corner_t c);
      longint p[4][3];
      tet_result_t r;
      if (c.corner != 2'd3) begin
        held[c.corner][0] = c.x;
        held[c.corner][1] = c.y;
        held[c.corner][2] = c.z;
        return;
      end
      for (int i = 0; i < 3; i++)
        for (int k = 0; k < 3; k++) p[i][k] = held[i][k];
      p[3][0] = c.x;
      p[3][1] = c.y;
      p[3][2] = c.z;
      r.quality = tet_quality(p);
      if (!c.skip && r.quality < min_worst) min_worst = r.quality;
      r.worst = min_worst;
      r.ok = (min_worst >= floor_q);
      r.skipped = c.skip;
      r.done = c.last;
      if (c.last) min_worst = init_worst;
      pending.push_back(r);
    endfunction

    function void check_result(logic [OUT_W-1:0] data, logic user, logic last);
      tet_result_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result data=%h", data);
        return;
      end
      e = pending.pop_front();
      if (data[QW-1:0] !== e.quality || data[2*QW-1:QW] !== e.worst ||
          data[2*QW] !== e.ok || user !== e.skipped || last !== e.done) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp q=%0d w=%0d ok=%b sk=%b dn=%b got q=%0d w=%0d ok=%b sk=%b dn=%b",
                   e.quality, e.worst, e.ok, e.skipped, e.done, data[QW-1:0],
                   data[2*QW-1:QW], data[2*QW], user, last);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;
  logic cfg_we_i = 1'b0;
  logic [REG_IDX_BITS-1:0] cfg_idx_i = '0;
  logic [QW-1:0] cfg_wdata_i = '0;

  quality_board board = new();
  corner_t corner_queue[$];
  corner_t in_flight;
  int burst_left = 0;
  int gap_left = 0;
  int stall_pct = 0;
  int mode_left = 0;
  int hold_left = 0;
  bit long_hold_req = 1'b0;

  tet_quality_min_check_core dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #100_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Sender: bursts of requests separated by random gaps
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) board.note_corner(in_flight);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0 || corner_queue.size() == 0) begin
          if (gap_left > 0) gap_left--;
          s_axis_tvalid <= 1'b0;
        end else begin
          in_flight = corner_queue.pop_front();
          s_axis_tdata <= {6'b0, in_flight.corner, in_flight.z, in_flight.y, in_flight.x};
          s_axis_tuser <= in_flight.skip;
          s_axis_tlast <= in_flight.last;
          s_axis_tvalid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
          end
        end
      end
    end
  end

  // Receiver: stall pattern that changes mode, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready)
        board.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
      if (long_hold_req && hold_left == 0) begin
        long_hold_req = 1'b0;
        hold_left = 4000;
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(50, 400);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 60;
          default: stall_pct = 95;
        endcase
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  function automatic logic signed [CW-1:0] rand_coord(int spread);
    return CW'($signed($urandom_range(0, 2 * spread)) - spread);
  endfunction

  task automatic push_corner(int x, int y, int z, logic [1:0] c, logic skip, logic last);
    corner_t it;
    it.x = CW'(x);
    it.y = CW'(y);
    it.z = CW'(z);
    it.corner = c;
    it.skip = skip;
    it.last = last;
    corner_queue.push_back(it);
  endtask

  task automatic write_cfg(logic [REG_IDX_BITS-1:0] idx, logic [QW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.write_reg(idx, val);
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (corner_queue.size() != 0 || s_axis_tvalid || board.pending.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Random tetrahedra: mostly complete corner runs, some stray corners
  task automatic random_tets(int n_items);
    int sent, spread, base_x, base_y, base_z;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 85) begin
        case ($urandom_range(0, 3))
          0: spread = 8388607;
          1: spread = 1000;
          2: spread = 8;
          default: spread = 100000;
        endcase
        base_x = (spread == 8388607) ? 0 : $signed($urandom_range(0, 8000000)) - 4000000;
        base_y = (spread == 8388607) ? 0 : $signed($urandom_range(0, 8000000)) - 4000000;
        base_z = (spread == 8388607) ? 0 : $signed($urandom_range(0, 8000000)) - 4000000;
        for (int c = 0; c < 4; c++)
          push_corner(base_x + rand_coord(spread), base_y + rand_coord(spread),
                      base_z + rand_coord(spread), 2'(c), 1'($urandom_range(0, 4) == 0),
                      1'($urandom_range(0, 7) == 0));
        sent += 4;
      end else begin
        push_corner($signed($urandom()) >>> 8, $signed($urandom()) >>> 8,
                    $signed($urandom()) >>> 8, 2'($urandom_range(0, 3)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: unit tetrahedron, then its inverted twin
    push_corner(0, 0, 0, 2'd0, 1'b1, 1'b1);
    push_corner(1, 0, 0, 2'd1, 1'b0, 1'b1);
    push_corner(0, 1, 0, 2'd2, 1'b1, 1'b0);
    push_corner(0, 0, 1, 2'd3, 1'b0, 1'b0);
    push_corner(0, 0, -1, 2'd3, 1'b0, 1'b0);
    // Degenerate: flat, then all corners equal
    push_corner(0, 0, 0, 2'd3, 1'b0, 1'b0);
    push_corner(5, 5, 5, 2'd0, 1'b0, 1'b0);
    push_corner(5, 5, 5, 2'd1, 1'b0, 1'b0);
    push_corner(5, 5, 5, 2'd2, 1'b0, 1'b0);
    push_corner(5, 5, 5, 2'd3, 1'b0, 1'b0);
    // Coordinate extremes, removed and then last
    push_corner(-8388608, -8388608, -8388608, 2'd0, 1'b0, 1'b0);
    push_corner(8388607, -8388608, -8388608, 2'd1, 1'b0, 1'b0);
    push_corner(-8388608, 8388607, -8388608, 2'd2, 1'b0, 1'b0);
    push_corner(-8388608, -8388608, 8388607, 2'd3, 1'b1, 1'b0);
    push_corner(-8388608, -8388608, 8388607, 2'd3, 1'b0, 1'b1);
    // Near-regular tetrahedron, corners out of order
    push_corner(100, 100, 100, 2'd2, 1'b0, 1'b0);
    push_corner(-100, -100, 100, 2'd1, 1'b0, 1'b0);
    push_corner(-100, 100, -100, 2'd0, 1'b0, 1'b0);
    push_corner(100, -100, -100, 2'd3, 1'b0, 1'b0);
    push_corner(100, -100, -100, 2'd3, 1'b0, 1'b1);
    // Sliver: a thin tetrahedron of low quality, still above the default floor
    push_corner(0, 0, 0, 2'd0, 1'b0, 1'b0);
    push_corner(8388607, 0, 0, 2'd1, 1'b0, 1'b0);
    push_corner(0, 8388607, 0, 2'd2, 1'b0, 1'b0);
    push_corner(1, 1, 1, 2'd3, 1'b0, 1'b1);
    random_tets(200);
    long_hold_req = 1'b1;
    drain();

    write_cfg(REG_QUALITY_FLOOR, '0);
    write_cfg(REG_INITIAL_WORST, QMAX);
    write_cfg(REG_SPARE, 48'h1234);
    random_tets(220);
    drain();

    write_cfg(REG_QUALITY_FLOOR, QMAX);
    write_cfg(REG_INITIAL_WORST, '0);
    random_tets(220);
    drain();

    write_cfg(REG_QUALITY_FLOOR, QW'({$urandom_range(0, 65535), $urandom()} >> 8));
    write_cfg(REG_INITIAL_WORST, QW'({$urandom_range(0, 65535), $urandom()} >> 6));
    random_tets(140);
    long_hold_req = 1'b1;
    drain();

    write_cfg(REG_QUALITY_FLOOR, QUALITY_FLOOR_RST[QW-1:0]);
    write_cfg(REG_INITIAL_WORST, INITIAL_WORST_RST[QW-1:0]);
    random_tets(120);
    drain();

    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ tet_quality_min_check_core.f @@
rtl/tqmc_pkg.sv
rtl/tet_quality_min_check_core.sv
sim/tb.sv
